[sv/value_noise_elevation_macros.svh]
// assertion macros shared by the checker of the elevation block
`ifndef VALUE_NOISE_ELEVATION_MACROS_SVH
`define VALUE_NOISE_ELEVATION_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define VNE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define VNE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/vne_pkg.sv]
// types, constants and shared arithmetic of the value noise elevation block
package vne_pkg;

  localparam int COORD_W    = 16;
  localparam int ELEV_W     = 16;
  localparam int SEED_W     = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int MARGIN_W   = 14;
  localparam int CELL_W     = 13;
  localparam int NUM_OCT    = 3;
  localparam int NUM_CORNER = 4;
  localparam int SUM_W      = 19;
  localparam int DIV_STEPS  = 16;
  localparam int PIPE_DEPTH = 19;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } vne_reg_e;

  localparam logic [SEED_W-1:0]   SEED_RST   = 64'd0;
  localparam logic [COORD_W-1:0]  WIDTH_RST  = 16'd256;
  localparam logic [COORD_W-1:0]  HEIGHT_RST = 16'd256;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 14'd42;

  // splitmix and lattice mixing constants
  localparam logic [63:0] SM_GOLDEN    = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] SM_MUL1      = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] SM_MUL2      = 64'h94D049BB133111EB;
  localparam logic [63:0] HASH_COL_MUL = 64'h00000100000001B3;
  localparam logic [63:0] HASH_ROW_MUL = 64'hC2B2AE3D27D4EB4F;

  // reciprocal multipliers for the constant divisions by 6 and by 7
  localparam logic [15:0] RECIP6       = 16'd43691;
  localparam int          RECIP6_SHIFT = 18;
  localparam logic [19:0] RECIP7       = 20'd599187;
  localparam int          RECIP7_SHIFT = 22;

  // log2 of the cell size per octave, coarse to fine
  localparam logic [3:0] CELL_SHIFT [NUM_OCT] = '{4'd8, 4'd6, 4'd4};

  // one classified request between front and back
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] bdist;
    logic               outside;
    logic               border;
  } vne_item_t;

  typedef struct packed {
    logic outside;
    logic border;
  } vne_flags_t;

  // a + floor((b - a) * w / 65536)
  function automatic logic [ELEV_W-1:0] blend16(input logic [ELEV_W-1:0] a,
                                                input logic [ELEV_W-1:0] b,
                                                input logic [ELEV_W-1:0] w);
    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic        [17:0] sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, w});
    sum  = {2'b00, a} + prod[33:16];
    return sum[ELEV_W-1:0];
  endfunction

endpackage

[sv/vne_if.sv]
// request channel and result channel of the elevation block
interface vne_pix_if;
  import vne_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_col;
  logic [COORD_W-1:0] pixel_row;
  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface vne_elev_if;
  import vne_pkg::*;
  logic              valid;
  logic              ready;
  logic [ELEV_W-1:0] elevation;
  logic              outside;
  modport source (output valid, output elevation, output outside, input ready);
  modport sink (input valid, input elevation, input outside, output ready);
endinterface

[sv/vne_front.sv]
// front stage: takes a request, checks the map bounds and border distance
module vne_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [vne_pkg::COORD_W-1:0]  col_i,
  input  logic [vne_pkg::COORD_W-1:0]  row_i,
  input  logic [vne_pkg::COORD_W-1:0]  width_i,
  input  logic [vne_pkg::COORD_W-1:0]  height_i,
  input  logic [vne_pkg::MARGIN_W-1:0] margin_i,
  output logic                         push_o,
  output vne_pkg::vne_item_t           item_o,
  input  logic                         full_i
);
  import vne_pkg::*;

  logic               fv_q, fv_d;
  logic [COORD_W-1:0] x_q, y_q, dist_q;
  logic               out_q;
  logic               outside;
  logic [COORD_W-1:0] dist_r, dist_b, min_x, min_y, near;
  logic               take;

  // distance to the nearest border, valid for inside tiles
  always_comb begin
    outside = (col_i >= width_i) || (row_i >= height_i);
    dist_r  = width_i - 16'd1 - col_i;
    dist_b  = height_i - 16'd1 - row_i;
    min_x   = (dist_r < col_i) ? dist_r : col_i;
    min_y   = (dist_b < row_i) ? dist_b : row_i;
    near    = (min_y < min_x) ? min_y : min_x;
  end

  assign push_o     = fv_q && !full_i;
  assign in_ready_o = !fv_q || !full_i;
  assign take       = in_valid_i && in_ready_o;

  // holding register valid
  always_comb begin
    fv_d = fv_q;
    if (take) begin
      fv_d = 1'b1;
    end else if (push_o) begin
      fv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      x_q    <= col_i;
      y_q    <= row_i;
      dist_q <= near;
      out_q  <= outside;
    end
  end

  // classify against the border margin
  always_comb begin
    item_o.x       = x_q;
    item_o.y       = y_q;
    item_o.bdist   = dist_q;
    item_o.outside = out_q;
    item_o.border  = (margin_i != '0) && (dist_q < COORD_W'(margin_i));
  end

endmodule

[sv/vne_fifo.sv]
// small request queue between the front and the back
module vne_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  vne_pkg::vne_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output vne_pkg::vne_item_t head_o
);
  import vne_pkg::*;

  vne_item_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

[sv/vne_hash.sv]
// pipelined splitmix hash of one lattice corner, low 16 bits of the result out
module vne_hash (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [vne_pkg::SEED_W-1:0]  seed_i,
  input  logic [1:0]                  oct_i,
  input  logic [vne_pkg::CELL_W-1:0]  cx_i,
  input  logic [vne_pkg::CELL_W-1:0]  cy_i,
  output logic [vne_pkg::ELEV_W-1:0]  val_o
);
  import vne_pkg::*;

  logic [63:0] col_term, row_lo, row_hi, key;
  logic [63:0] mx1, mx2;
  logic [63:0] key_q, sum_q, mx1_q, pa_q, pb_q, pc_q;
  logic [63:0] mx2_q, pd_q, pe_q, pf_q;
  logic [31:0] mx1h_q, mx2h_q;

  // corner key from seed, octave and lattice position
  always_comb begin
    col_term = 64'(cx_i) * HASH_COL_MUL;
    row_lo   = 64'(cy_i) * 64'(HASH_ROW_MUL[31:0]);
    row_hi   = 64'(cy_i) * 64'(HASH_ROW_MUL[63:32]);
    key      = seed_i ^ {6'd0, oct_i, 56'd0} ^ col_term ^ (row_lo + (row_hi << 32));
    mx1      = sum_q ^ (sum_q >> 30);
    mx2      = pc_q ^ (pc_q >> 27);
  end

  // each 64-bit product is built from three 32-bit partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      key_q  <= key;
      sum_q  <= key_q + SM_GOLDEN;
      mx1_q  <= mx1;
      pa_q   <= 64'(mx1[31:0]) * 64'(SM_MUL1[31:0]);
      mx1h_q <= mx1_q[63:32];
      pb_q   <= pa_q + {mx1_q[31:0] * SM_MUL1[63:32], 32'd0};
      pc_q   <= pb_q + {mx1h_q * SM_MUL1[31:0], 32'd0};
      mx2_q  <= mx2;
      pd_q   <= 64'(mx2[31:0]) * 64'(SM_MUL2[31:0]);
      mx2h_q <= mx2_q[63:32];
      pe_q   <= pd_q + {mx2_q[31:0] * SM_MUL2[63:32], 32'd0};
      pf_q   <= pe_q + {mx2h_q * SM_MUL2[31:0], 32'd0};
    end
  end

  assign val_o = pf_q[15:0] ^ pf_q[46:31];

endmodule

[sv/vne_smooth.sv]
// two-stage smoothstep in unsigned 0.16: t*t*(3 - 2t)
module vne_smooth (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [vne_pkg::ELEV_W-1:0] t_i,
  output logic [vne_pkg::ELEV_W-1:0] s_o
);
  import vne_pkg::*;

  logic [31:0] tt_q;
  logic [17:0] k_q;
  logic [49:0] prod;
  logic [ELEV_W-1:0] s_q;

  assign prod = 50'(tt_q) * 50'(k_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tt_q <= 32'(t_i) * 32'(t_i);
      k_q  <= 18'h30000 - {1'b0, t_i, 1'b0};
      s_q  <= prod[47:32];
    end
  end

  assign s_o = s_q;

endmodule

[sv/vne_back.sv]
// back pipeline: octave hashing, blending, divide by 7 and border fade
module vne_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [vne_pkg::SEED_W-1:0]   seed_i,
  input  logic [vne_pkg::MARGIN_W-1:0] margin_i,
  input  vne_pkg::vne_item_t           head_i,
  input  logic                         head_valid_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [vne_pkg::ELEV_W-1:0]   elevation_o,
  output logic                         outside_o
);
  import vne_pkg::*;

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_q;

  logic [ELEV_W-1:0] corner [NUM_OCT][NUM_CORNER];
  logic [ELEV_W-1:0] sm_t   [NUM_OCT][2];
  logic [ELEV_W-1:0] tw_q   [7][NUM_OCT][2];
  logic [ELEV_W-1:0] top_q  [NUM_OCT];
  logic [ELEV_W-1:0] bot_q  [NUM_OCT];
  logic [ELEV_W-1:0] mix_q  [NUM_OCT];
  logic [SUM_W-1:0]  sum_q;
  logic [38:0]       prod_q;
  logic [ELEV_W-1:0] val_q;
  logic [ELEV_W-1:0] val_dly_q [5];

  logic [16:0]        dv_shift  [DIV_STEPS];
  logic [COORD_W-1:0] dv_rem_in [DIV_STEPS];
  logic [COORD_W-1:0] dv_quo_in [DIV_STEPS];
  logic [COORD_W-1:0] dv_rem_d  [DIV_STEPS];
  logic [COORD_W-1:0] dv_quo_d  [DIV_STEPS];
  logic [COORD_W-1:0] dv_rem_q  [DIV_STEPS];
  logic [COORD_W-1:0] dv_quo_q  [DIV_STEPS];
  logic [ELEV_W-1:0]  bord_s;

  vne_flags_t        flg_q [PIPE_DEPTH-1];
  logic [31:0]       scaled;
  logic [ELEV_W-1:0] elev_d, elev_q;
  logic              outside_q;

  // whole pipeline advances unless the result register is held
  assign en          = !vld_q[PIPE_DEPTH-1] || out_ready_i;
  assign pop_o       = en;
  assign out_valid_o = vld_q[PIPE_DEPTH-1];
  assign elevation_o = elev_q;
  assign outside_o   = outside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], head_valid_i};
    end
  end

  // corner hashes and fraction smoothing per octave
  for (genvar o = 0; o < NUM_OCT; o++) begin : g_oct
    for (genvar c = 0; c < NUM_CORNER; c++) begin : g_corner
      vne_hash u_hash (
        .clk_i  (clk_i),
        .en_i   (en),
        .seed_i (seed_i),
        .oct_i  (2'(o)),
        .cx_i   (CELL_W'(head_i.x >> CELL_SHIFT[o]) + CELL_W'(c % 2)),
        .cy_i   (CELL_W'(head_i.y >> CELL_SHIFT[o]) + CELL_W'(c / 2)),
        .val_o  (corner[o][c])
      );
    end
    vne_smooth u_smx (
      .clk_i (clk_i),
      .en_i  (en),
      .t_i   (16'(head_i.x << (16 - CELL_SHIFT[o]))),
      .s_o   (sm_t[o][0])
    );
    vne_smooth u_smy (
      .clk_i (clk_i),
      .en_i  (en),
      .t_i   (16'(head_i.y << (16 - CELL_SHIFT[o]))),
      .s_o   (sm_t[o][1])
    );
  end

  // bit-per-stage divider for distance * 65536 / margin
  always_comb begin
    dv_rem_in[0] = head_i.bdist;
    dv_quo_in[0] = '0;
    for (int i = 1; i < DIV_STEPS; i++) begin
      dv_rem_in[i] = dv_rem_q[i-1];
      dv_quo_in[i] = dv_quo_q[i-1];
    end
    for (int i = 0; i < DIV_STEPS; i++) begin
      dv_shift[i] = {dv_rem_in[i], 1'b0};
      if (dv_shift[i] >= 17'(margin_i)) begin
        dv_rem_d[i] = 16'(dv_shift[i] - 17'(margin_i));
        dv_quo_d[i] = {dv_quo_in[i][14:0], 1'b1};
      end else begin
        dv_rem_d[i] = dv_shift[i][15:0];
        dv_quo_d[i] = {dv_quo_in[i][14:0], 1'b0};
      end
    end
  end

  vne_smooth u_smb (
    .clk_i (clk_i),
    .en_i  (en),
    .t_i   (dv_quo_q[DIV_STEPS-1]),
    .s_o   (bord_s)
  );

  // final fade, zero for outside tiles
  always_comb begin
    scaled = 32'(val_dly_q[4]) * 32'(bord_s);
    elev_d = val_dly_q[4];
    if (flg_q[PIPE_DEPTH-2].border) begin
      elev_d = scaled[31:16];
    end
    if (flg_q[PIPE_DEPTH-2].outside) begin
      elev_d = '0;
    end
  end

  // data stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_rem_q <= dv_rem_d;
      dv_quo_q <= dv_quo_d;
      tw_q[0]  <= sm_t;
      for (int k = 1; k < 7; k++) begin
        tw_q[k] <= tw_q[k-1];
      end
      for (int o = 0; o < NUM_OCT; o++) begin
        top_q[o] <= blend16(corner[o][0], corner[o][1], tw_q[5][o][0]);
        bot_q[o] <= blend16(corner[o][2], corner[o][3], tw_q[5][o][0]);
        mix_q[o] <= blend16(top_q[o], bot_q[o], tw_q[6][o][1]);
      end
      sum_q  <= {1'b0, mix_q[0], 2'b00} + {2'b00, mix_q[1], 1'b0} + {3'b000, mix_q[2]};
      prod_q <= 39'(sum_q) * 39'(RECIP7);
      val_q  <= prod_q[RECIP7_SHIFT +: ELEV_W];
      val_dly_q[0] <= val_q;
      for (int k = 1; k < 5; k++) begin
        val_dly_q[k] <= val_dly_q[k-1];
      end
      flg_q[0] <= '{outside: head_i.outside, border: head_i.border};
      for (int k = 1; k < PIPE_DEPTH - 1; k++) begin
        flg_q[k] <= flg_q[k-1];
      end
      elev_q    <= elev_d;
      outside_q <= flg_q[PIPE_DEPTH-2].outside;
    end
  end

endmodule

[sv/value_noise_elevation.sv]
// Fractal value noise elevation: one 16-bit elevation per tile coordinate.
// Requests arrive on pix_i (pixel_col, pixel_row) with valid/ready; results
// leave on elev_o (elevation, outside) with valid/ready, one per request and
// in request order. Configuration is a plain write port: cfg_we_i, register
// index cfg_idx_i (0 seed, 1 width, 2 height) and cfg_data_i; write it only
// while no request is in flight.
// Throughput is one request per cycle while elev_o is not stalled. A request
// passes one front register, the request queue, and a 19-stage back pipeline
// set by the border divider (16 steps, one quotient bit each) followed by its
// smoothstep and the fade multiply.
// When the receiver holds ready low while a result waits, the back pipeline
// freezes; the 4-entry queue and the front register keep taking requests
// until they fill, then pix_i.ready drops. Reset empties queue and pipeline
// and loads seed 0 and a 256 by 256 map.
module value_noise_elevation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vne_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vne_pkg::SEED_W-1:0]    cfg_data_i,
  vne_pix_if.sink                       pix_i,
  vne_elev_if.source                    elev_o
);
  import vne_pkg::*;

  logic [SEED_W-1:0]   seed_q;
  logic [COORD_W-1:0]  width_q, height_q, min_side;
  logic [MARGIN_W-1:0] margin_q;
  logic [31:0]         margin_prod;

  logic      push, full, pop, head_valid;
  vne_item_t push_item, head_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= SEED_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SEED:   seed_q   <= cfg_data_i;
        REG_WIDTH:  width_q  <= cfg_data_i[COORD_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // border margin: min side / 6
  assign min_side    = (width_q < height_q) ? width_q : height_q;
  assign margin_prod = 32'(min_side) * 32'(RECIP6);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MARGIN_RST;
    end else begin
      margin_q <= margin_prod[RECIP6_SHIFT +: MARGIN_W];
    end
  end

  vne_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (pix_i.ready),
    .col_i      (pix_i.pixel_col),
    .row_i      (pix_i.pixel_row),
    .width_i    (width_q),
    .height_i   (height_q),
    .margin_i   (margin_q),
    .push_o     (push),
    .item_o     (push_item),
    .full_i     (full)
  );

  vne_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head_item)
  );

  vne_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_i       (seed_q),
    .margin_i     (margin_q),
    .head_i       (head_item),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_valid_o  (elev_o.valid),
    .out_ready_i  (elev_o.ready),
    .elevation_o  (elev_o.elevation),
    .outside_o    (elev_o.outside)
  );

endmodule

[sv/vne_checker.sv]
// port-level checks of the elevation block and their binding
`include "value_noise_elevation_macros.svh"

module vne_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [vne_pkg::ELEV_W-1:0] elevation_i,
  input logic                       outside_i
);
  import vne_pkg::*;

  logic [5:0] pend_q, pend_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // requests taken but not yet answered
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 6'd1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `VNE_ASSERT_IMP(a_outside_zero, out_valid_i && outside_i, elevation_i == '0, "outside tile gave nonzero elevation")
  `VNE_ASSERT_NXT(a_result_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(elevation_i) && $stable(outside_i), "held result changed")
  `VNE_ASSERT_IMP(a_no_extra, out_valid_i, pend_q != '0, "result without a pending request")
  `VNE_ASSERT_IMP(a_bounded, 1'b1, pend_q <= 6'd32, "more requests in flight than storage")

endmodule

bind value_noise_elevation vne_checker u_vne_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (elev_o.valid),
  .out_ready_i (elev_o.ready),
  .elevation_i (elev_o.elevation),
  .outside_i   (elev_o.outside)
);

[tb/tb_value_noise_elevation.sv]
// self-checking testbench of the value noise elevation block
module tb_value_noise_elevation;
  import vne_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } tile_req_t;

  typedef struct packed {
    logic [ELEV_W-1:0] elevation;
    logic              outside;
  } elev_res_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [SEED_W-1:0] cfg_data_i = '0;

  vne_pix_if  pix_if ();
  vne_elev_if elev_if ();

  value_noise_elevation u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if.sink),
    .elev_o     (elev_if.source)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state mirrors the configuration registers
  logic [63:0] seed_q = 64'd0;
  logic [15:0] width_q = 16'd256;
  logic [15:0] height_q = 16'd256;

  tile_req_t tile_queue[$];
  elev_res_t elev_expected[$];
  int errors = 0;
  int n_results = 0;
  int n_outside = 0;
  int n_faded = 0;

  function automatic logic [63:0] splitmix(input logic [63:0] v);
    v = v + 64'h9E3779B97F4A7C15;
    v = (v ^ (v >> 30)) * 64'hBF58476D1CE4E5B9;
    v = (v ^ (v >> 27)) * 64'h94D049BB133111EB;
    return v ^ (v >> 31);
  endfunction

  function automatic longint lattice_hash(input int oct, input longint cx, input longint cy);
    logic [63:0] h;
    h = splitmix(seed_q ^ (64'(oct) << 56) ^ (64'(cx) * 64'h100000001B3)
                 ^ (64'(cy) * 64'hC2B2AE3D27D4EB4F));
    return longint'({48'd0, h[15:0]});
  endfunction

  function automatic longint smoothstep16(input longint t);
    logic [63:0] r;
    r = (64'(t) * 64'(t) * (64'd196608 - 64'd2 * 64'(t))) >> 32;
    return longint'(r);
  endfunction

  // arithmetic shift is floor division by 65536
  function automatic longint mix16(input longint a, input longint b, input longint w);
    return a + ((b - a) * w >>> 16);
  endfunction

  function automatic elev_res_t tile_elevation(input tile_req_t r);
    elev_res_t res;
    longint x, y, sum, val, margin, bdist, cell_sz, cx, cy, tx, ty, top, bot;
    int wgt;
    x = r.col;
    y = r.row;
    res = '0;
    if (x >= width_q || y >= height_q) begin
      res.outside = 1'b1;
      return res;
    end
    sum = 0;
    for (int o = 0; o < 3; o++) begin
      cell_sz = 256 >> (2 * o);
      wgt = 4 >> o;
      cx = x / cell_sz;
      cy = y / cell_sz;
      tx = smoothstep16(((x % cell_sz) * 65536) / cell_sz);
      ty = smoothstep16(((y % cell_sz) * 65536) / cell_sz);
      top = mix16(lattice_hash(o, cx, cy), lattice_hash(o, cx + 1, cy), tx);
      bot = mix16(lattice_hash(o, cx, cy + 1), lattice_hash(o, cx + 1, cy + 1), tx);
      sum += wgt * mix16(top, bot, ty);
    end
    val = sum / 7;
    margin = ((width_q < height_q) ? width_q : height_q) / 6;
    bdist = x;
    if (width_q - 1 - x < bdist) bdist = width_q - 1 - x;
    if (y < bdist) bdist = y;
    if (height_q - 1 - y < bdist) bdist = height_q - 1 - y;
    if (margin > 0 && bdist < margin)
      val = (val * smoothstep16((bdist * 65536) / margin)) >>> 16;
    if (val < 0) val = 0;
    if (val > 65535) val = 65535;
    res.elevation = val[15:0];
    return res;
  endfunction

  // driver: bursts of requests with random gaps
  int burst_left = 0;
  int gap_left = 0;
  logic hold_src = 1'b0;
  tile_req_t acc_tile;
  initial begin
    pix_if.valid = 1'b0;
    pix_if.pixel_col = '0;
    pix_if.pixel_row = '0;
  end
  always @(posedge clk_i) begin
    if (pix_if.valid && pix_if.ready) begin
      acc_tile = tile_queue.pop_front();
      elev_expected = {elev_expected, tile_elevation(acc_tile)};
    end
    if (pix_if.valid && !pix_if.ready) begin
      // keep offering
    end else if (hold_src) begin
      pix_if.valid <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      pix_if.valid <= 1'b0;
    end else if (tile_queue.size() > 0) begin
      pix_if.valid <= 1'b1;
      pix_if.pixel_col <= tile_queue[0].col;
      pix_if.pixel_row <= tile_queue[0].row;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 30);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      pix_if.valid <= 1'b0;
    end
  end

  // receiver stall pattern plus one long hold-off
  int stall_phase = 0;
  int long_hold = 0;
  logic long_hold_req = 1'b0;
  initial elev_if.ready = 1'b0;
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (long_hold_req && long_hold == 0) begin
      long_hold <= 200;
      elev_if.ready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      elev_if.ready <= (long_hold == 1);
    end else if (stall_phase % 512 < 128) begin
      elev_if.ready <= 1'b1;
    end else begin
      elev_if.ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 37 != 5);
    end
  end

  // monitor: compare results with the oldest expectation
  elev_res_t exp_r;
  always @(posedge clk_i) begin
    if (rst_ni && elev_if.valid && elev_if.ready) begin
      n_results++;
      if (elev_expected.size() == 0) begin
        $display("%0t: unexpected result elevation=%0d outside=%0b", $time,
                 elev_if.elevation, elev_if.outside);
        errors++;
      end else begin
        exp_r = elev_expected.pop_front();
        if (exp_r.outside) n_outside++;
        if (elev_if.elevation !== exp_r.elevation) begin
          $display("%0t: elevation mismatch expected %0d actual %0d", $time,
                   exp_r.elevation, elev_if.elevation);
          errors++;
        end
        if (elev_if.outside !== exp_r.outside) begin
          $display("%0t: outside mismatch expected %0b actual %0b", $time,
                   exp_r.outside, elev_if.outside);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (elev_if.valid && elev_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input vne_reg_e idx, input logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SEED:   seed_q = data;
      REG_WIDTH:  width_q = data[15:0];
      REG_HEIGHT: height_q = data[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (tile_queue.size() > 0 || elev_expected.size() > 0 || pix_if.valid)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_tile(input int col, input int row);
    tile_req_t r;
    r.col = col[15:0];
    r.row = row[15:0];
    tile_queue = {tile_queue, r};
  endtask

  // mostly inside the map, some past the edges, some anywhere
  task automatic push_random(input int count);
    int c, r, sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        c = $urandom_range(0, width_q - 1);
        r = $urandom_range(0, height_q - 1);
      end else if (sel < 9) begin
        c = $urandom_range(0, width_q + 3);
        r = $urandom_range(0, height_q + 3);
      end else begin
        c = $urandom_range(0, 65535);
        r = $urandom_range(0, 65535);
      end
      push_tile(c, r);
    end
  endtask

  task automatic count_faded();
    int m;
    m = ((width_q < height_q) ? width_q : height_q) / 6;
    if (m > 0) n_faded++;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset map, corners, edges, outside
    push_tile(0, 0);
    push_tile(255, 255);
    push_tile(255, 0);
    push_tile(0, 255);
    push_tile(128, 128);
    push_tile(42, 42);
    push_tile(41, 100);
    push_tile(256, 10);
    push_tile(10, 256);
    push_tile(65535, 65535);
    push_tile(15, 63);
    push_tile(16, 64);
    wait_idle();

    // extreme seed and full-size map
    write_reg(REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_WIDTH, 65535);
    write_reg(REG_HEIGHT, 65535);
    push_tile(65534, 65534);
    push_tile(32768, 32768);
    push_tile(65535, 0);
    push_tile(10922, 21845);
    push_tile(43690, 10921);
    wait_idle();

    // tiny map: margin zero, and zero width
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 5);
    push_tile(0, 0);
    push_tile(0, 4);
    push_tile(1, 0);
    wait_idle();
    write_reg(REG_WIDTH, 0);
    push_tile(0, 0);
    wait_idle();

    // random phases over several settings
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_SEED, {$urandom, $urandom});
      write_reg(REG_WIDTH, (ph == 0) ? 16'd1 : (ph == 1) ? 16'd65535
                           : 16'($urandom_range(1, 700)));
      write_reg(REG_HEIGHT, (ph == 2) ? 16'd1 : (ph == 3) ? 16'd65535
                            : 16'($urandom_range(1, 700)));
      count_faded();
      if (ph == 3) long_hold_req <= 1'b1;
      push_random(200);
      if (ph == 3) begin
        repeat (5) @(posedge clk_i);
        long_hold_req <= 1'b0;
      end
      if (ph == 5) begin
        // sender pauses until every result is back
        while (tile_queue.size() > 100) @(posedge clk_i);
        hold_src <= 1'b1;
        while (elev_expected.size() > 0) @(posedge clk_i);
        hold_src <= 1'b0;
      end
      wait_idle();
    end

    $display("covered %0d results, %0d outside tiles, %0d settings with border fade",
             n_results, n_outside, n_faded);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/vne_pkg.sv
sv/vne_if.sv
sv/vne_front.sv
sv/vne_fifo.sv
sv/vne_hash.sv
sv/vne_smooth.sv
sv/vne_back.sv
sv/value_noise_elevation.sv
sv/vne_checker.sv
tb/tb_value_noise_elevation.sv
